// ===== hdl/wlsv_pkg.sv =====
// wlsv_pkg: shared types and helpers for the wall-law slip velocity pipeline.
// No dependencies.
`default_nettype none
package wlsv_pkg;

  // Sideband carried alongside the square-root pipeline
  typedef struct packed {
    logic [2:0][31:0] up;   // tangential velocity per axis, signed
    logic [30:0]      mu;   // total diffusivity
    logic [63:0]      t4;   // alpha*rho*u_tau^2*y, saturated
    logic             yp;   // y+ above one
  } sq_side_t;

  // Sideband carried alongside the divider pipeline
  typedef struct packed {
    logic [2:0][31:0] up;
    logic             law;
  } dv_side_t;

  // Arithmetic shift right that truncates toward zero
  function automatic logic signed [127:0] shr_tz(input logic signed [127:0] x,
                                                 input int unsigned s);
    logic [127:0] mag;
    logic [127:0] shf;
    mag = x[127] ? 128'(-x) : 128'(x);
    shf = mag >> s;
    return x[127] ? -$signed(shf) : $signed(shf);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fff_ffff;
    if (x < -128'sd2147483648) return 32'sh8000_0000;
    return 32'(x);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wlsv_front.sv =====
// wlsv_front: six-stage front end: normal removal, tangential velocity,
// squared norm and the wall-law numerator t4. Uses wlsv_pkg.
`default_nettype none
module wlsv_front import wlsv_pkg::*; #(
  parameter int DIMENSION = 3,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic signed [17:0] unit_normal_x,
  input  wire logic signed [17:0] unit_normal_y,
  input  wire logic signed [17:0] unit_normal_z,
  input  wire logic [30:0]        wall_distance,
  input  wire logic [30:0]        friction_velocity,
  input  wire logic [30:0]        kinematic_viscosity,
  input  wire logic [30:0]        density,
  input  wire logic [16:0]        volume_fraction,
  input  wire logic [30:0]        total_diffusivity,
  output logic                    out_valid,
  output logic [63:0]             sum_sq,
  output sq_side_t                out_side
);

  logic signed [31:0] v_in [3];
  logic signed [17:0] n_in [3];

  assign v_in[0] = vel_x;
  assign v_in[1] = vel_y;
  assign v_in[2] = (DIMENSION > 2) ? vel_z : '0;
  assign n_in[0] = unit_normal_x;
  assign n_in[1] = unit_normal_y;
  assign n_in[2] = (DIMENSION > 2) ? unit_normal_z : '0;

  logic [5:0] vld;

  // stage A
  logic signed [31:0] v_a [3];
  logic signed [17:0] n_a [3];
  logic signed [49:0] p_a [3];
  logic [61:0]        yu_a, uu_a;
  logic [47:0]        ar_a;
  logic [30:0]        y_a, nu_a, mu_a;
  // stage B
  logic signed [31:0] v_b [3];
  logic signed [17:0] n_b [3];
  logic signed [51:0] dq_b;
  logic               yp_b;
  logic [47:0]        t1_b;
  logic [61:0]        t2_b;
  logic [30:0]        y_b, mu_b;
  // stage C
  logic signed [31:0] v_c [3];
  logic signed [69:0] m_c [3];
  logic [78:0]        pl_c, ph_c;
  logic               yp_c;
  logic [30:0]        y_c, mu_c;
  // stage D
  logic signed [31:0] up_d [3];
  logic [63:0]        t3_d;
  logic               yp_d;
  logic [30:0]        y_d, mu_d;
  // stage E
  logic [63:0]        sq_e [3];
  logic signed [31:0] up_e [3];
  logic [62:0]        ql_e, qh_e;
  logic               yp_e;
  logic [30:0]        mu_e;
  // stage F
  logic [63:0]        sq_f;
  logic signed [31:0] up_f [3];
  logic [63:0]        t4_f;
  logic               yp_f;
  logic [30:0]        mu_f;

  logic signed [51:0] dot;
  logic [111:0]       p3;
  logic [95:0]        p4;
  logic signed [63:0] sq_s [3];

  always_comb begin
    dot = 52'(p_a[0]) + 52'(p_a[1]) + 52'(p_a[2]);
    p3  = 112'(pl_c) + (112'(ph_c) << 31);
    p4  = 96'(ql_e) + (96'(qh_e) << 32);
    for (int d = 0; d < 3; d++) begin
      sq_s[d] = up_d[d] * up_d[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 3; d++) begin
        v_a[d]  <= v_in[d];
        n_a[d]  <= n_in[d];
        p_a[d]  <= v_in[d] * n_in[d];
        v_b[d]  <= v_a[d];
        n_b[d]  <= n_a[d];
        v_c[d]  <= v_b[d];
        m_c[d]  <= dq_b * n_b[d];
        up_d[d] <= sat32(128'(v_c[d]) - shr_tz(128'(m_c[d]), FRAC_BITS));
        sq_e[d] <= 64'(sq_s[d]);
        up_e[d] <= up_d[d];
        up_f[d] <= up_e[d];
      end
      yu_a <= wall_distance * friction_velocity;
      uu_a <= friction_velocity * friction_velocity;
      ar_a <= volume_fraction * density;
      y_a  <= wall_distance;
      nu_a <= kinematic_viscosity;
      mu_a <= total_diffusivity;

      dq_b <= 52'(shr_tz(128'(dot), FRAC_BITS));
      yp_b <= {2'b00, yu_a} > (64'(nu_a) << FRAC_BITS);
      t1_b <= ar_a >> FRAC_BITS;
      t2_b <= uu_a >> FRAC_BITS;
      y_b  <= y_a;
      mu_b <= mu_a;

      pl_c <= t1_b * t2_b[30:0];
      ph_c <= t1_b * t2_b[61:31];
      yp_c <= yp_b;
      y_c  <= y_b;
      mu_c <= mu_b;

      t3_d <= ((|p3[111:64]) ? {64{1'b1}} : p3[63:0]) >> FRAC_BITS;
      yp_d <= yp_c;
      y_d  <= y_c;
      mu_d <= mu_c;

      ql_e <= t3_d[31:0] * y_d;
      qh_e <= t3_d[63:32] * y_d;
      yp_e <= yp_d;
      mu_e <= mu_d;

      sq_f <= sq_e[0] + sq_e[1] + sq_e[2];
      t4_f <= ((|p4[95:64]) ? {64{1'b1}} : p4[63:0]) >> FRAC_BITS;
      yp_f <= yp_e;
      mu_f <= mu_e;
    end
  end

  assign out_valid = vld[5];
  assign sum_sq    = sq_f;
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      out_side.up[d] = up_f[d];
    end
    out_side.mu = mu_f;
    out_side.t4 = t4_f;
    out_side.yp = yp_f;
  end

endmodule
`default_nettype wire

// ===== hdl/wlsv_sqrt.sv =====
// wlsv_sqrt: 32-stage pipelined integer square root, one result bit per stage.
// Uses wlsv_pkg for the sideband type.
`default_nettype none
module wlsv_sqrt import wlsv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [63:0] radicand,
  input  wire sq_side_t    in_side,
  output logic             out_valid,
  output logic [31:0]      root,
  output sq_side_t         out_side
);

  localparam int NS = 32;

  logic [35:0] rem_r  [NS];
  logic [31:0] root_r [NS];
  logic [63:0] rad_r  [NS];
  sq_side_t    side_r [NS];
  logic [NS-1:0] vld;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [35:0] rem_p, rem_t, trial;
    logic [31:0] root_p;
    logic [63:0] rad_p;
    sq_side_t    side_p;
    logic        vld_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = radicand;
      assign side_p = in_side;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign rem_t = {rem_p[33:0], rad_p[63:62]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_t - trial : rem_t;
        root_r[k] <= {root_p[30:0], ge};
        rad_r[k]  <= {rad_p[61:0], 2'b00};
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign root      = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

// ===== hdl/wlsv_div.sv =====
// wlsv_div: denominator product and pipelined restoring divider giving the
// capped coefficient c = t4 * 2^F / (|u_par| * mu). Uses wlsv_pkg.
`default_nettype none
module wlsv_div import wlsv_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int K = 33 + FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] norm,
  input  wire sq_side_t    in_side,
  output logic             out_valid,
  output logic [K-1:0]     coef,
  output dv_side_t         out_side
);

  localparam logic [K-1:0] CAP = K'(1) << (32 + FRAC_BITS);

  // stage 0: denominator
  logic        vld0;
  logic [62:0] den0;
  logic [63:0] t40;
  dv_side_t    side0;
  // stage 1: overflow check and remainder seed
  logic        vld1, ovf1;
  logic [62:0] den1, rem1;
  logic [K-1:0] num1;
  dv_side_t    side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den0      <= norm * in_side.mu;
      t40       <= in_side.t4;
      side0.up  <= in_side.up;
      side0.law <= in_side.yp && (|norm);
      // quotient at or above 2^(33+F) (or zero divisor) means the cap
      ovf1  <= (t40 >> 33) >= 64'(den0);
      rem1  <= 63'(t40[63:33]);
      num1  <= K'(t40[32:0]) << FRAC_BITS;
      den1  <= den0;
      side1 <= side0;
    end
  end

  logic [62:0]  rem_r  [K];
  logic [62:0]  den_r  [K];
  logic [K-1:0] num_r  [K];
  logic [K-1:0] q_r    [K];
  logic         ovf_r  [K];
  dv_side_t     side_r [K];
  logic [K-1:0] vld;

  for (genvar j = 0; j < K; j++) begin : g_step
    logic [62:0]  rem_p, den_p;
    logic [K-1:0] num_p, q_p;
    logic         ovf_p, vld_p, ge;
    logic [63:0]  r2;
    dv_side_t     side_p;

    if (j == 0) begin : g_first
      assign rem_p  = rem1;
      assign den_p  = den1;
      assign num_p  = num1;
      assign q_p    = '0;
      assign ovf_p  = ovf1;
      assign side_p = side1;
      assign vld_p  = vld1;
    end else begin : g_next
      assign rem_p  = rem_r[j-1];
      assign den_p  = den_r[j-1];
      assign num_p  = num_r[j-1];
      assign q_p    = q_r[j-1];
      assign ovf_p  = ovf_r[j-1];
      assign side_p = side_r[j-1];
      assign vld_p  = vld[j-1];
    end

    assign r2 = {rem_p, num_p[K-1]};
    assign ge = r2 >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? 63'(r2 - {1'b0, den_p}) : r2[62:0];
        den_r[j]  <= den_p;
        num_r[j]  <= num_p << 1;
        q_r[j]    <= {q_p[K-2:0], ge};
        ovf_r[j]  <= ovf_p;
        side_r[j] <= side_p;
      end
    end
  end

  assign out_valid = vld[K-1];
  assign coef      = (ovf_r[K-1] || (q_r[K-1] > CAP)) ? CAP : q_r[K-1];
  assign out_side  = side_r[K-1];

endmodule
`default_nettype wire

// ===== hdl/wlsv_scale.sv =====
// wlsv_scale: three-stage output scaling u_par * (1 - c) with saturation;
// the last stage is the output register. Uses wlsv_pkg.
`default_nettype none
module wlsv_scale import wlsv_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int K = 33 + FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [K-1:0]  coef,
  input  wire dv_side_t      in_side,
  output logic               out_valid,
  output logic [2:0][31:0]   vel,
  output logic               law
);

  localparam int LW = 25;
  localparam int HW = K - LW;
  localparam int PW = 32 + K;
  localparam logic [K-1:0] ONE = K'(1) << FRAC_BITS;

  logic [2:0] vld;

  logic [K-1:0]  mf1;
  logic [31:0]   mu1 [3];
  logic [2:0]    neg1;
  logic          law1;

  logic [31+LW:0] pl2 [3];
  logic [31+HW:0] ph2 [3];
  logic [2:0]     neg2;
  logic           law2;

  logic signed [K:0] f;
  logic [32:0]       ue [3];
  logic [PW-1:0]     p [3];
  logic [PW-1:0]     m [3];
  logic [31:0]       res [3];

  always_comb begin
    f = $signed({1'b0, ONE}) - $signed({1'b0, coef});
    for (int d = 0; d < 3; d++) begin
      ue[d] = {in_side.up[d][31], in_side.up[d]};
      p[d]  = PW'(pl2[d]) + (PW'(ph2[d]) << LW);
      m[d]  = p[d] >> FRAC_BITS;
      if (!law2) begin
        res[d] = '0;
      end else if (neg2[d]) begin
        res[d] = (m[d] >= PW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-m[d]);
      end else begin
        res[d] = (m[d] > PW'(32'h7fff_ffff)) ? 32'h7fff_ffff : m[d][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mf1  <= f[K] ? K'(-f) : K'(f);
      law1 <= in_side.law;
      for (int d = 0; d < 3; d++) begin
        mu1[d]  <= ue[d][32] ? 32'(-ue[d]) : ue[d][31:0];
        neg1[d] <= ue[d][32] ^ f[K];
        pl2[d]  <= mu1[d] * mf1[LW-1:0];
        ph2[d]  <= mu1[d] * mf1[K-1:LW];
        vel[d]  <= res[d];
      end
      neg2 <= neg1;
      law2 <= law1;
      law  <= law2;
    end
  end

  assign out_valid = vld[2];

endmodule
`default_nettype wire

// ===== hdl/wall_law_slip_velocity_top.sv =====
// Stages: 6 front-end stages, 32 square-root stages, 35 + FRAC_BITS divider
// stages, 3 scaling stages; values are Q16.16 at the default FRAC_BITS of 16.
// Throughput: one request per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset (rst, synchronous) clears all valid bits; no clearing pass.
`default_nettype none
module wall_law_slip_velocity_top import wlsv_pkg::*; #(
  parameter int DIMENSION = 3,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic signed [17:0] unit_normal_x,
  input  wire logic signed [17:0] unit_normal_y,
  input  wire logic signed [17:0] unit_normal_z,
  input  wire logic [30:0]        wall_distance,
  input  wire logic [30:0]        friction_velocity,
  input  wire logic [30:0]        kinematic_viscosity,
  input  wire logic [30:0]        density,
  input  wire logic [16:0]        volume_fraction,
  input  wire logic [30:0]        total_diffusivity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      wall_vel_x,
  output logic signed [31:0]      wall_vel_y,
  output logic signed [31:0]      wall_vel_z,
  output logic                    law_applied
);

  localparam int K = 33 + FRAC_BITS;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic        fr_valid, sq_valid, dv_valid;
  logic [63:0] sum_sq;
  logic [31:0] norm;
  logic [K-1:0] coef;
  sq_side_t    fr_side, sq_side;
  dv_side_t    dv_side;
  logic [2:0][31:0] vel;

  wlsv_front #(.DIMENSION(DIMENSION), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en, .in_valid,
    .vel_x, .vel_y, .vel_z,
    .unit_normal_x, .unit_normal_y, .unit_normal_z,
    .wall_distance, .friction_velocity, .kinematic_viscosity,
    .density, .volume_fraction, .total_diffusivity,
    .out_valid(fr_valid), .sum_sq(sum_sq), .out_side(fr_side)
  );

  wlsv_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid(fr_valid), .radicand(sum_sq), .in_side(fr_side),
    .out_valid(sq_valid), .root(norm), .out_side(sq_side)
  );

  wlsv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .en,
    .in_valid(sq_valid), .norm(norm), .in_side(sq_side),
    .out_valid(dv_valid), .coef(coef), .out_side(dv_side)
  );

  wlsv_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk, .rst, .en,
    .in_valid(dv_valid), .coef(coef), .in_side(dv_side),
    .out_valid(out_valid), .vel(vel), .law(law_applied)
  );

  assign wall_vel_x = vel[0];
  assign wall_vel_y = vel[1];
  assign wall_vel_z = vel[2];

endmodule
`default_nettype wire

// ===== hdl/wlsv_chk.sv =====
// wlsv_chk: port-level checks for wall_law_slip_velocity_top, bound to it.
// Depends on the top level's port list only.
`default_nettype none
module wlsv_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] wall_vel_x,
  input wire logic [31:0] wall_vel_y,
  input wire logic [31:0] wall_vel_z,
  input wire logic        law_applied
);

  // input side only backs up when a finished result is held
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held output");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled request withdrawn");

  a_zero_when_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !law_applied |->
      wall_vel_x == 32'h0 && wall_vel_y == 32'h0 && wall_vel_z == 32'h0)
    else $error("nonzero velocity without wall law");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(wall_vel_x)
      && $stable(wall_vel_y) && $stable(wall_vel_z) && $stable(law_applied))
    else $error("stalled result changed");

endmodule

bind wall_law_slip_velocity_top wlsv_chk u_wlsv_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .wall_vel_x(wall_vel_x), .wall_vel_y(wall_vel_y), .wall_vel_z(wall_vel_z),
  .law_applied(law_applied)
);
`default_nettype wire
